// ===== rtl/core/ascii_motion_command_parser_assert.svh =====
// Assertion macros shared by the motion command parser RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASCII_MOTION_COMMAND_PARSER_ASSERT_SVH
`define ASCII_MOTION_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define AMCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define AMCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/amcp_pkg.sv =====
// Types, character codes and helper functions for the motion command parser.
// Used by amcp_parser and ascii_motion_command_parser; depends on nothing.
`timescale 1ns / 1ps

package amcp_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Largest magnitudes a 16-bit signed number may take.
    localparam logic [19:0] MAG_POS_MAX = 20'd32767;
    localparam logic [19:0] MAG_NEG_MAX = 20'd32768;

    typedef enum logic [3:0] {
        TP_IDLE   = 4'd0,
        TP_LSTART = 4'd1,
        TP_LNEED  = 4'd2,
        TP_LDIG   = 4'd3,
        TP_RSTART = 4'd4,
        TP_RNEED  = 4'd5,
        TP_RDIG   = 4'd6,
        TP_OK     = 4'd7,
        TP_BAD    = 4'd8
    } t_track_phase;

    typedef enum logic [2:0] {
        LP_IDLE  = 3'd0,
        LP_DIGIT = 3'd1,
        LP_BOUND = 3'd2,
        LP_OK    = 3'd3,
        LP_BAD   = 3'd4
    } t_light_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FRAMING = 3'd1,
        ST_BAD_TRK = 3'd2,
        ST_BAD_LGT = 3'd3,
        ST_NOTHING = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic               stop_flag;
        logic               track_present;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               light_present;
        logic               light_state;
    } t_result;

    function automatic logic is_bnd(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_COMMA) || (c == CH_SLASH) || (c == CH_COLON) ||
               (c == CH_UNDER) || (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/core/amcp_parser.sv =====
// Token detectors, track and light field parsers and the final verdict.
// Depends on amcp_pkg and ascii_motion_command_parser_assert.svh.
`timescale 1ns / 1ps
`include "ascii_motion_command_parser_assert.svh"

module amcp_parser #(
    parameter int unsigned BUFFER_BYTES = 192
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  amcp_pkg::t_item i_item,
    output amcp_pkg::t_result o_result
);
    import amcp_pkg::*;

    localparam logic [7:0] BufLimit = 8'(BUFFER_BYTES);

    logic [39:0]  r_recent, n_recent;
    logic [7:0]   r_count, n_count;
    logic         r_text_ended, n_text_ended;
    logic         r_stop, n_stop;
    t_track_phase r_tp, n_tp;
    logic [15:0]  r_mag, n_mag;
    logic         r_neg, n_neg;
    logic [15:0]  r_left, n_left;
    logic [15:0]  r_right, n_right;
    t_light_phase r_lp, n_lp;
    logic         r_light, n_light;

    logic [7:0]   c, p1, p2, p3, p4, p5;
    logic [19:0]  prod;
    logic         dig_ok, c_dig, c_bnd, stop_hit;
    logic [15:0]  taken;
    logic [7:0]   count_inc;

    // Values after the byte itself has been fed.
    logic         f_text_ended, f_stop, f_neg, f_light;
    t_track_phase f_tp;
    t_light_phase f_lp;
    logic [15:0]  f_mag, f_left, f_right;

    // Values after the implied trailing zero.
    t_track_phase e_tp;
    t_light_phase e_lp;
    logic [15:0]  e_right;
    logic         framing;

    always_comb begin
        c  = i_item.data_byte;
        p1 = r_recent[7:0];
        p2 = r_recent[15:8];
        p3 = r_recent[23:16];
        p4 = r_recent[31:24];
        p5 = r_recent[39:32];

        c_dig = is_digit(c);
        c_bnd = is_bnd(c);
        prod  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {16'd0, c[3:0]};
        dig_ok = c_dig && (prod <= (r_neg ? MAG_NEG_MAX : MAG_POS_MAX));
        taken = r_neg ? (16'd0 - r_mag) : r_mag;

        stop_hit = (c == CH_SLASH) &&
            (((r_count >= 8'd2) && (p1 == CH_T) && (p2 == CH_Z) &&
              ((r_count == 8'd2) || is_bnd(p3))) ||
             ((r_count >= 8'd4) && (p1 == CH_P) && (p2 == CH_COLON) &&
              (p3 == CH_T) && (p4 == CH_S) && ((r_count == 8'd4) || is_bnd(p5))));

        f_text_ended = r_text_ended;
        f_stop  = r_stop;
        f_tp    = r_tp;
        f_mag   = r_mag;
        f_neg   = r_neg;
        f_left  = r_left;
        f_right = r_right;
        f_lp    = r_lp;
        f_light = r_light;

        if (!r_text_ended) begin
            if (stop_hit) begin
                f_stop = 1'b1;
            end
            case (r_tp)
                TP_LSTART, TP_RSTART: begin
                    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                        f_neg = (c == CH_MINUS);
                        f_tp  = (r_tp == TP_LSTART) ? TP_LNEED : TP_RNEED;
                    end else if (dig_ok) begin
                        f_mag = prod[15:0];
                        f_tp  = (r_tp == TP_LSTART) ? TP_LDIG : TP_RDIG;
                    end else begin
                        f_tp = TP_BAD;
                    end
                end
                TP_LNEED, TP_RNEED: begin
                    if (dig_ok) begin
                        f_mag = prod[15:0];
                        f_tp  = (r_tp == TP_LNEED) ? TP_LDIG : TP_RDIG;
                    end else begin
                        f_tp = TP_BAD;
                    end
                end
                TP_LDIG: begin
                    if (c_dig) begin
                        f_mag = dig_ok ? prod[15:0] : r_mag;
                        f_tp  = dig_ok ? TP_LDIG : TP_BAD;
                    end else if ((c == CH_UNDER) || (c == CH_COMMA)) begin
                        f_left = taken;
                        f_mag  = 16'd0;
                        f_neg  = 1'b0;
                        f_tp   = TP_RSTART;
                    end else begin
                        f_tp = TP_BAD;
                    end
                end
                TP_RDIG: begin
                    if (c_dig) begin
                        f_mag = dig_ok ? prod[15:0] : r_mag;
                        f_tp  = dig_ok ? TP_RDIG : TP_BAD;
                    end else if (c_bnd) begin
                        f_right = taken;
                        f_mag   = 16'd0;
                        f_neg   = 1'b0;
                        f_tp    = TP_OK;
                    end else begin
                        f_tp = TP_BAD;
                    end
                end
                TP_IDLE: begin
                    if ((c == CH_UNDER) && (r_count >= 8'd1) && (p1 == CH_L) &&
                        ((r_count == 8'd1) || is_bnd(p2))) begin
                        f_mag = 16'd0;
                        f_neg = 1'b0;
                        f_tp  = TP_LSTART;
                    end
                end
                default: ;
            endcase

            case (r_lp)
                LP_DIGIT: begin
                    if ((c == CH_ZERO) || (c == CH_ONE)) begin
                        f_light = c[0];
                        f_lp    = LP_BOUND;
                    end else begin
                        f_lp = LP_BAD;
                    end
                end
                LP_BOUND: f_lp = c_bnd ? LP_OK : LP_BAD;
                LP_IDLE: begin
                    if (((c == CH_COLON) || (c == CH_UNDER)) && (r_count >= 8'd1) &&
                        (p1 == CH_D) && ((r_count == 8'd1) || is_bnd(p2))) begin
                        f_lp = LP_DIGIT;
                    end
                end
                default: ;
            endcase

            if (c == CH_NUL) begin
                f_text_ended = 1'b1;
            end
        end

        // The text is always closed by an implied zero, which is a boundary.
        e_tp    = f_tp;
        e_lp    = f_lp;
        e_right = f_right;
        if (!f_text_ended) begin
            case (f_tp)
                TP_RDIG: begin
                    e_tp    = TP_OK;
                    e_right = f_neg ? (16'd0 - f_mag) : f_mag;
                end
                TP_LSTART, TP_LNEED, TP_LDIG, TP_RSTART, TP_RNEED: e_tp = TP_BAD;
                default: ;
            endcase
            case (f_lp)
                LP_DIGIT: e_lp = LP_BAD;
                LP_BOUND: e_lp = LP_OK;
                default: ;
            endcase
        end

        count_inc = (r_count == 8'hFF) ? r_count : (r_count + 8'd1);
        framing   = (count_inc >= BufLimit) || (c != CH_SLASH);

        o_result = '0;
        if (framing) begin
            o_result.status = ST_FRAMING;
        end else if (e_tp == TP_BAD) begin
            o_result.status = ST_BAD_TRK;
        end else if (e_lp == LP_BAD) begin
            o_result.status = ST_BAD_LGT;
        end else if (!f_stop && (e_tp != TP_OK) && (e_lp != LP_OK)) begin
            o_result.status = ST_NOTHING;
        end else begin
            o_result.status    = ST_OK;
            o_result.stop_flag = f_stop;
            if (e_tp == TP_OK) begin
                o_result.track_present = 1'b1;
                o_result.left_speed    = f_left;
                o_result.right_speed   = e_right;
            end
            if (e_lp == LP_OK) begin
                o_result.light_present = 1'b1;
                o_result.light_state   = f_light;
            end
        end

        // Each datagram starts from a clean state.
        if (i_item.end_of_datagram) begin
            n_recent     = '0;
            n_count      = '0;
            n_text_ended = 1'b0;
            n_stop       = 1'b0;
            n_tp         = TP_IDLE;
            n_mag        = '0;
            n_neg        = 1'b0;
            n_left       = '0;
            n_right      = '0;
            n_lp         = LP_IDLE;
            n_light      = 1'b0;
        end else begin
            n_recent     = r_text_ended ? r_recent : {r_recent[31:0], c};
            n_count      = count_inc;
            n_text_ended = f_text_ended;
            n_stop       = f_stop;
            n_tp         = f_tp;
            n_mag        = f_mag;
            n_neg        = f_neg;
            n_left       = f_left;
            n_right      = f_right;
            n_lp         = f_lp;
            n_light      = f_light;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent     <= '0;
            r_count      <= '0;
            r_text_ended <= 1'b0;
            r_stop       <= 1'b0;
            r_tp         <= TP_IDLE;
            r_mag        <= '0;
            r_neg        <= 1'b0;
            r_left       <= '0;
            r_right      <= '0;
            r_lp         <= LP_IDLE;
            r_light      <= 1'b0;
        end else if (i_advance) begin
            r_recent     <= n_recent;
            r_count      <= n_count;
            r_text_ended <= n_text_ended;
            r_stop       <= n_stop;
            r_tp         <= n_tp;
            r_mag        <= n_mag;
            r_neg        <= n_neg;
            r_left       <= n_left;
            r_right      <= n_right;
            r_lp         <= n_lp;
            r_light      <= n_light;
        end
    end

    `AMCP_ASSERT_NEXT(a_clean_after_last, i_advance && i_item.end_of_datagram,
        (r_tp == TP_IDLE) && (r_lp == LP_IDLE) && (r_count == 8'd0) && !r_stop,
        "parser state not cleared after the final byte")
    `AMCP_ASSERT_NEXT(a_history_frozen, r_text_ended && !(i_advance && i_item.end_of_datagram),
        $stable(r_recent), "byte history moved after the text ended")
    `AMCP_ASSERT_NOW(a_idle_values_zero, r_tp == TP_IDLE,
        (r_left == 16'd0) && (r_right == 16'd0),
        "track values set before a track field started")

endmodule

// ===== rtl/core/ascii_motion_command_parser.sv =====
// A datagram's result is loaded into the result register when its final byte moves on from the byte register.
// Throughput: one byte per cycle; only a final byte holds in the byte register,
// and only while an earlier result waits unaccepted in the result register.
// The parser state updates once per byte through one combinational pass.
// Reset: synchronous, active low; clears the parser state and both valid flags.
// Depends on amcp_pkg, amcp_parser and ascii_motion_command_parser_assert.svh.
`timescale 1ns / 1ps
`include "ascii_motion_command_parser_assert.svh"

module ascii_motion_command_parser #(
    parameter int unsigned BUFFER_BYTES = 192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_datagram
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] stop_flag, [1] track_present, [17:2] left_speed,
    // [33:18] right_speed, [34] light_present, [35] light_state, [39:36] zero
    output logic [39:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    import amcp_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;

    // A final byte may only move on once the result register has room.
    assign advance = r_in_valid && (!r_in.end_of_datagram || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.data_byte       <= s_axis_tdata;
            r_in.end_of_datagram <= s_axis_tlast;
        end
    end

    amcp_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.end_of_datagram) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.end_of_datagram) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {4'b0000, r_out.light_state, r_out.light_present,
                            r_out.right_speed, r_out.left_speed,
                            r_out.track_present, r_out.stop_flag};

    `AMCP_ASSERT_NEXT(a_result_follows_last, advance && r_in.end_of_datagram,
        r_out_valid, "no result after the final byte of a datagram")
    `AMCP_ASSERT_NEXT(a_held_byte_kept, r_in_valid && !advance,
        r_in_valid && $stable(r_in), "held byte lost or changed while waiting")
    `AMCP_ASSERT_NOW(a_error_fields_zero, r_out_valid && (r_out.status != ST_OK),
        m_axis_tdata == 40'd0, "fields not cleared on an error status")

endmodule
